[design/next_permutation_engine_top_defines.svh]
// Assertion macros for the permutation engine.
// Included by design/next_permutation_engine_top.sv; expects clk and rst_n in scope.
`ifndef NEXT_PERMUTATION_ENGINE_TOP_DEFINES_SVH
`define NEXT_PERMUTATION_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// clocked property, masked while in reset
`define NPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression must never hold
`define NPE_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define NPE_ASSERT(lbl, prop, msg)
`define NPE_NEVER(lbl, expr, msg)
`endif

`endif

[design/npe_pkg.sv]
// Shared types and constants for the permutation engine.
// No dependencies; imported by next_permutation_engine_top.
package npe_pkg;

  localparam int MAX_LEN   = 16;
  localparam int ELEM_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_LEN);
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int CFG_W     = 5;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef logic signed [ELEM_BITS-1:0] elem_t;

  typedef struct packed {
    logic              op;
    logic signed [15:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] elem_value;
    logic               no_next;
    logic               last;
  } out_rsp_t;

endpackage

[design/next_permutation_engine_top.sv]
// Next-permutation engine: load items are written straight into the element store;
// a step scans for the pivot, searches for the pick, swaps them, reverses the suffix
// and streams the L = length items out (or flags no next); the one read port paces it.
// in_ready is low for the whole step; results drain through an output register.
// Synchronous active-low reset clears control, load pointer and length (16);
// element store contents are undefined until loaded.
`include "next_permutation_engine_top_defines.svh"

module next_permutation_engine_top (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  npe_pkg::in_req_t  in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output npe_pkg::out_rsp_t out_data,
  // length register
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata
);
  import npe_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // take loads / wait for step
  localparam logic [2:0] ST_SCAN = 3'd1;  // find rightmost ascent, right to left
  localparam logic [2:0] ST_SRCH = 3'd2;  // find rightmost element above pivot
  localparam logic [2:0] ST_SWAP = 3'd3;  // second half of pivot swap
  localparam logic [2:0] ST_REV  = 3'd4;  // reverse the suffix, one pair at a time
  localparam logic [2:0] ST_EMIT = 3'd5;  // stream sequence out
  localparam logic [2:0] ST_NOUT = 3'd6;  // report last arrangement

  // element store, one write and one registered read port
  elem_t mem [MAX_LEN];

  logic [2:0]       state_r, state_nxt;
  logic [CFG_W-1:0] cfg_len_r;
  logic [IDX_W-1:0] ld_ptr_r, ld_ptr_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;      // read issue pointer
  logic             iss_done_r, iss_done_nxt;
  logic             tag_vld_r, tag_vld_nxt; // rdata_r holds a tagged read
  logic [IDX_W-1:0] tag_idx_r, tag_idx_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_rsp_t         out_data_r, out_data_nxt;

  elem_t            rdata_r;
  elem_t            prev_r, prev_nxt;
  elem_t            pivval_r, pivval_nxt;
  elem_t            a_r, a_nxt;
  logic [IDX_W-1:0] pivot_r, pivot_nxt;
  logic [IDX_W-1:0] pick_r, pick_nxt;
  logic [IDX_W-1:0] lo_r, lo_nxt;
  logic [IDX_W-1:0] hi_r, hi_nxt;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  elem_t            mem_wdata;

  logic [LEN_W-1:0] len_eff;
  logic [IDX_W-1:0] len_m1;
  logic [IDX_W-1:0] ld_pos;
  logic [LEN_W-1:0] ld_next;
  logic [IDX_W-1:0] lo_first;
  logic             out_free;
  logic             load_now;
  logic             emit_last;

  // length clamped to 1..MAX_LEN
  always_comb begin
    if (cfg_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(cfg_len_r) > MAX_LEN) begin
      len_eff = LEN_W'(MAX_LEN);
    end else begin
      len_eff = LEN_W'(cfg_len_r);
    end
  end
  assign len_m1 = IDX_W'(len_eff - LEN_W'(1));

  // pointer left past a shortened length restarts at position 0
  assign ld_pos  = (LEN_W'(ld_ptr_r) < len_eff) ? ld_ptr_r : '0;
  assign ld_next = LEN_W'(ld_pos) + LEN_W'(1);

  assign lo_first  = pivot_r + IDX_W'(1);
  assign out_free  = !out_valid_r || out_ready;
  assign load_now  = tag_vld_r && out_free;
  assign emit_last = (tag_idx_r == len_m1);

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    ld_ptr_nxt    = ld_ptr_r;
    ptr_nxt       = ptr_r;
    iss_done_nxt  = iss_done_r;
    tag_vld_nxt   = 1'b0;
    tag_idx_nxt   = tag_idx_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    prev_nxt      = prev_r;
    pivval_nxt    = pivval_r;
    a_nxt         = a_r;
    pivot_nxt     = pivot_r;
    pick_nxt      = pick_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    rd_en         = 1'b0;
    rd_addr       = ptr_r;
    mem_we        = 1'b0;
    mem_waddr     = ptr_r;
    mem_wdata     = pivval_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.op == OP_LOAD) begin
            mem_we     = 1'b1;
            mem_waddr  = ld_pos;
            mem_wdata  = elem_t'(in_data.value);
            ld_ptr_nxt = (ld_next >= len_eff) ? '0 : ld_next[IDX_W-1:0];
          end else begin
            state_nxt    = ST_SCAN;
            ptr_nxt      = len_m1;
            iss_done_nxt = 1'b0;
          end
        end
      end

      ST_SCAN, ST_SRCH: begin
        // descending reads, one per cycle
        if (!iss_done_r) begin
          rd_en        = 1'b1;
          rd_addr      = ptr_r;
          tag_vld_nxt  = 1'b1;
          tag_idx_nxt  = ptr_r;
          ptr_nxt      = ptr_r - IDX_W'(1);
          iss_done_nxt = (ptr_r == '0);
        end
        if (tag_vld_r) begin
          if (state_r == ST_SCAN) begin
            prev_nxt = rdata_r;
            if (tag_idx_r != len_m1 && rdata_r < prev_r) begin
              pivot_nxt    = tag_idx_r;
              pivval_nxt   = rdata_r;
              state_nxt    = ST_SRCH;
              ptr_nxt      = len_m1;
              iss_done_nxt = 1'b0;
              tag_vld_nxt  = 1'b0;
            end else if (tag_idx_r == '0) begin
              state_nxt   = ST_NOUT;
              tag_vld_nxt = 1'b0;
            end
          end else if (rdata_r > pivval_r) begin
            // first half of swap: pivot slot takes the picked value
            pick_nxt    = tag_idx_r;
            mem_we      = 1'b1;
            mem_waddr   = pivot_r;
            mem_wdata   = rdata_r;
            state_nxt   = ST_SWAP;
            tag_vld_nxt = 1'b0;
          end
        end
      end

      ST_SWAP: begin
        mem_we    = 1'b1;
        mem_waddr = pick_r;
        mem_wdata = pivval_r;
        lo_nxt    = lo_first;
        hi_nxt    = len_m1;
        phase_nxt = 2'd0;
        if (lo_first < len_m1) begin
          state_nxt = ST_REV;
        end else begin
          state_nxt    = ST_EMIT;
          ptr_nxt      = '0;
          iss_done_nxt = 1'b0;
        end
      end

      ST_REV: begin
        phase_nxt = phase_r + 2'd1;
        case (phase_r)
          2'd0: begin
            rd_en   = 1'b1;
            rd_addr = lo_r;
          end
          2'd1: begin
            rd_en   = 1'b1;
            rd_addr = hi_r;
            a_nxt   = rdata_r;
          end
          2'd2: begin
            mem_we    = 1'b1;
            mem_waddr = lo_r;
            mem_wdata = rdata_r;
          end
          default: begin
            mem_we    = 1'b1;
            mem_waddr = hi_r;
            mem_wdata = a_r;
            lo_nxt    = lo_r + IDX_W'(1);
            hi_nxt    = hi_r - IDX_W'(1);
            if (LEN_W'(lo_r) + LEN_W'(2) >= LEN_W'(hi_r)) begin
              state_nxt    = ST_EMIT;
              ptr_nxt      = '0;
              iss_done_nxt = 1'b0;
            end
          end
        endcase
      end

      ST_EMIT: begin
        if (load_now) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.elem_value = 16'(rdata_r);
          out_data_nxt.no_next    = 1'b0;
          out_data_nxt.last       = emit_last;
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
        if (!iss_done_r && (!tag_vld_r || load_now)) begin
          rd_en        = 1'b1;
          rd_addr      = ptr_r;
          tag_vld_nxt  = 1'b1;
          tag_idx_nxt  = ptr_r;
          ptr_nxt      = ptr_r + IDX_W'(1);
          iss_done_nxt = (ptr_r == len_m1);
        end else begin
          tag_vld_nxt = tag_vld_r && !load_now;
        end
      end

      ST_NOUT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.elem_value = '0;
          out_data_nxt.no_next    = 1'b1;
          out_data_nxt.last       = 1'b1;
          state_nxt               = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_len_r   <= CFG_W'(16);
      ld_ptr_r    <= '0;
      ptr_r       <= '0;
      iss_done_r  <= 1'b0;
      tag_vld_r   <= 1'b0;
      phase_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ld_ptr_r    <= ld_ptr_nxt;
      ptr_r       <= ptr_nxt;
      iss_done_r  <= iss_done_nxt;
      tag_vld_r   <= tag_vld_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_len_r <= cfg_wdata;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    tag_idx_r  <= tag_idx_nxt;
    out_data_r <= out_data_nxt;
    prev_r     <= prev_nxt;
    pivval_r   <= pivval_nxt;
    a_r        <= a_nxt;
    pivot_r    <= pivot_nxt;
    pick_r     <= pick_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
  end

  // element store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // checks
  `NPE_ASSERT(a_rev_bounds, (state_r == ST_REV) |-> (lo_r < hi_r), "reverse pointers crossed")
  `NPE_ASSERT(a_nonext_fmt, (out_valid_r && out_data_r.no_next) |-> (out_data_r.last && out_data_r.elem_value == 16'sd0), "bad no-next result")
  `NPE_ASSERT(a_emit_idx, (state_r == ST_EMIT && tag_vld_r) |-> (tag_idx_r <= len_m1), "emit index past length")
  `NPE_NEVER(a_no_wr_emit, mem_we && (state_r == ST_SCAN || state_r == ST_EMIT || state_r == ST_NOUT), "store written in read-only state")

endmodule
